// File: rtl/core/pksc_pkg.sv
`timescale 1ns / 1ps

package pksc_pkg;

	localparam int MAX_SIDE  = 6;
	localparam int KEY_DEPTH = 64;

	localparam int CELLS    = MAX_SIDE * MAX_SIDE;
	localparam int LETTERS  = 26;
	localparam int CELL_AW  = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int LETTER_W = $clog2(LETTERS);
	localparam int COORD_W  = $clog2(MAX_SIDE + 1);
	localparam int SIDE_W   = COORD_W;
	localparam int KEY_AW   = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
	localparam int KEY_CW   = $clog2(KEY_DEPTH + 1);
	localparam int KEY_VW   = 5;

	localparam int CHAR_W   = 8;
	localparam int FIELD_W  = 3;
	localparam int IN_W     = 16;
	localparam int CFG_IW   = 2;
	localparam int CFG_DW   = 3;

	localparam logic [CHAR_W-1:0] CHAR_A     = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_0     = 8'h30;
	localparam logic [CHAR_W-1:0] CASE_OFS   = 8'd32;
	localparam logic [CHAR_W-1:0] LETTER_SPAN = 8'(LETTERS - 1);
	localparam logic [CHAR_W-1:0] DIGIT_SPAN = 8'd9;

	localparam logic [CFG_IW-1:0] CFG_DECRYPT  = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_SIDE     = 2'd1;
	localparam logic [CFG_IW-1:0] CFG_KEY_KIND = 2'd2;

	localparam logic [CFG_DW-1:0] SIDE_RESET = 3'd5;

	typedef enum logic [FIELD_W-1:0] {
		CMD_CELL    = 3'd0,
		CMD_KEY     = 3'd1,
		CMD_TEXT    = 3'd2,
		CMD_CLEAR   = 3'd3,
		CMD_RESTART = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_NO_LETTER  = 2'd1,
		ST_KEY_EMPTY  = 2'd2,
		ST_CELL_EMPTY = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WR_OLD,
		S_WR_SET,
		S_LOOK,
		S_SHIFT,
		S_FETCH,
		S_OUT
	} state_t;

	typedef struct packed {
		logic accept;
		logic wr_old;
		logic wr_set;
		logic look;
		logic shift;
		logic fetch;
		logic emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic go_write;
		logic go_text;
		logic go_empty;
		logic l2c_hit;
		logic out_free;
	} dp_stat_t;

	typedef struct packed {
		logic                ok;
		logic [LETTER_W-1:0] idx;
	} letter_t;

	function automatic letter_t letter_of(input logic [CHAR_W-1:0] c);
		letter_t l;
		l.ok  = 1'b0;
		l.idx = '0;
		if (c >= CHAR_A && c <= CHAR_A + LETTER_SPAN) begin
			l.ok  = 1'b1;
			l.idx = LETTER_W'(c - CHAR_A);
		end else if (c >= CHAR_A + CASE_OFS && c <= CHAR_A + CASE_OFS + LETTER_SPAN) begin
			l.ok  = 1'b1;
			l.idx = LETTER_W'(c - CHAR_A - CASE_OFS);
		end
		return l;
	endfunction

	// Restoring remainder, one quotient bit per step.
	function automatic logic [SIDE_W-1:0] mod_side(input logic [KEY_VW-1:0] v,
			input logic [SIDE_W-1:0] s);
		logic [KEY_VW+SIDE_W-1:0] r;
		logic [KEY_VW+SIDE_W-1:0] d;
		r = (KEY_VW + SIDE_W)'(v);
		for (int i = KEY_VW - 1; i >= 0; i--) begin
			d = (KEY_VW + SIDE_W)'(s) << i;
			if (r >= d) r = r - d;
		end
		return r[SIDE_W-1:0];
	endfunction

	// base and k both below s, so one conditional subtract wraps the result.
	function automatic logic [SIDE_W-1:0] shift_coord(input logic [SIDE_W-1:0] base,
			input logic [SIDE_W-1:0] k, input logic [SIDE_W-1:0] s, input logic dec);
		logic [SIDE_W:0] t;
		if (dec) t = {1'b0, base} + {1'b0, s} - {1'b0, k};
		else     t = {1'b0, base} + {1'b0, k};
		if (t >= {1'b0, s}) t = t - {1'b0, s};
		return t[SIDE_W-1:0];
	endfunction

endpackage

// File: rtl/core/pksc_ram.sv
`timescale 1ns / 1ps

module pksc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/core/pksc_ctrl.sv
`timescale 1ns / 1ps

module pksc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  pksc_pkg::dp_stat_t    stat,
	output logic                  s_tready,
	output pksc_pkg::ctrl_cmd_t   cmd
);

	pksc_pkg::state_t state_q, state_d;
	logic accept;

	assign s_tready = (state_q == pksc_pkg::S_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= pksc_pkg::S_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pksc_pkg::S_IDLE: begin
				if (accept) begin
					priority if (stat.go_write) state_d = pksc_pkg::S_WR_OLD;
					else if (stat.go_text)      state_d = pksc_pkg::S_LOOK;
					else if (stat.go_empty)     state_d = pksc_pkg::S_OUT;
				end
			end
			pksc_pkg::S_WR_OLD: state_d = pksc_pkg::S_WR_SET;
			pksc_pkg::S_WR_SET: state_d = pksc_pkg::S_IDLE;
			pksc_pkg::S_LOOK:   state_d = stat.l2c_hit ? pksc_pkg::S_SHIFT : pksc_pkg::S_OUT;
			pksc_pkg::S_SHIFT:  state_d = pksc_pkg::S_FETCH;
			pksc_pkg::S_FETCH:  state_d = pksc_pkg::S_OUT;
			pksc_pkg::S_OUT:    if (stat.out_free) state_d = pksc_pkg::S_IDLE;
			default:            state_d = pksc_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		cmd.accept = accept;
		unique case (state_q)
			pksc_pkg::S_WR_OLD: cmd.wr_old = 1'b1;
			pksc_pkg::S_WR_SET: cmd.wr_set = 1'b1;
			pksc_pkg::S_LOOK:   cmd.look   = 1'b1;
			pksc_pkg::S_SHIFT:  cmd.shift  = 1'b1;
			pksc_pkg::S_FETCH:  cmd.fetch  = 1'b1;
			pksc_pkg::S_OUT:    cmd.emit   = stat.out_free;
			default:            ;
		endcase
	end

endmodule

// File: rtl/core/pksc_dp.sv
`timescale 1ns / 1ps

module pksc_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [pksc_pkg::CFG_IW-1:0]        cfg_idx,
	input  logic [pksc_pkg::CFG_DW-1:0]        cfg_data,
	input  logic [pksc_pkg::FIELD_W-1:0]       in_cmd,
	input  logic [pksc_pkg::IN_W-1:0]          in_data,
	input  logic                               m_tready,
	input  pksc_pkg::ctrl_cmd_t                cmd,
	output pksc_pkg::dp_stat_t                 stat,
	output logic                               m_tvalid,
	output logic [pksc_pkg::CHAR_W-1:0]        m_tdata,
	output logic [1:0]                         m_tuser
);

	localparam int CW = pksc_pkg::COORD_W;
	localparam int LW = pksc_pkg::LETTER_W;
	localparam int SW = pksc_pkg::SIDE_W;

	// configuration
	logic                          decrypt_q;
	logic [pksc_pkg::CFG_DW-1:0]   side_q;
	logic                          key_kind_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decrypt_q  <= 1'b0;
			side_q     <= pksc_pkg::SIDE_RESET;
			key_kind_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				pksc_pkg::CFG_DECRYPT:  decrypt_q  <= cfg_data[0];
				pksc_pkg::CFG_SIDE:     side_q     <= cfg_data;
				pksc_pkg::CFG_KEY_KIND: key_kind_q <= cfg_data[0];
				default:                ;
			endcase
		end
	end

	// input decode
	pksc_pkg::cmd_t                      op;
	logic [pksc_pkg::FIELD_W-1:0]        row_in, col_in;
	logic [pksc_pkg::CHAR_W-1:0]         ch_in;
	pksc_pkg::letter_t                   lt;
	logic                                row_ok, col_ok;
	logic [pksc_pkg::CELL_AW-1:0]        cell_in;
	logic                                key_ok, key_full, key_wr;
	logic [pksc_pkg::KEY_VW-1:0]         key_val;
	logic                                text_letter;

	assign op     = pksc_pkg::cmd_t'(in_cmd);
	assign row_in = in_data[2:0];
	assign col_in = in_data[5:3];
	assign ch_in  = in_data[13:6];
	assign lt     = pksc_pkg::letter_of(ch_in);
	assign row_ok = (row_in != '0) && (int'(row_in) <= pksc_pkg::MAX_SIDE);
	assign col_ok = (col_in != '0) && (int'(col_in) <= pksc_pkg::MAX_SIDE);
	assign cell_in = pksc_pkg::CELL_AW'((int'(row_in) - 1) * pksc_pkg::MAX_SIDE
			+ int'(col_in) - 1);

	always_comb begin
		if (key_kind_q) begin
			key_ok  = lt.ok;
			key_val = pksc_pkg::KEY_VW'(lt.idx) + pksc_pkg::KEY_VW'(1);
		end else begin
			key_ok  = (ch_in >= pksc_pkg::CHAR_0)
				&& (ch_in <= pksc_pkg::CHAR_0 + pksc_pkg::DIGIT_SPAN);
			key_val = pksc_pkg::KEY_VW'(ch_in - pksc_pkg::CHAR_0);
		end
	end

	logic [pksc_pkg::KEY_CW-1:0] key_count_q;
	logic [pksc_pkg::KEY_AW-1:0] key_pos_q;
	logic [pksc_pkg::KEY_AW-1:0] kp;
	logic [pksc_pkg::KEY_CW-1:0] kp_inc;

	assign key_full = (key_count_q == pksc_pkg::KEY_CW'(pksc_pkg::KEY_DEPTH));
	assign key_wr   = cmd.accept && (op == pksc_pkg::CMD_KEY) && key_ok && !key_full;
	assign kp       = (pksc_pkg::KEY_CW'(key_pos_q) < key_count_q) ? key_pos_q : '0;
	assign kp_inc   = pksc_pkg::KEY_CW'(kp) + pksc_pkg::KEY_CW'(1);

	assign text_letter   = (op == pksc_pkg::CMD_TEXT) && lt.ok;
	assign stat.go_write = (op == pksc_pkg::CMD_CELL) && lt.ok && row_ok && col_ok;
	assign stat.go_text  = text_letter && (key_count_q != '0);
	assign stat.go_empty = text_letter && (key_count_q == '0);

	// item registers
	logic [LW-1:0]                li_q;
	logic [CW-1:0]                row_q, col_q;
	logic [pksc_pkg::CELL_AW-1:0] cell_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			li_q   <= lt.idx;
			row_q  <= CW'(row_in);
			col_q  <= CW'(col_in);
			cell_q <= cell_in;
		end
	end

	// tables
	logic [2*CW-1:0]              l2c_rdata;
	logic [LW-1:0]                l2c_raddr;
	logic [LW-1:0]                c2l_rdata;
	logic [pksc_pkg::CELL_AW-1:0] c2l_raddr;
	logic [pksc_pkg::KEY_VW-1:0]  key_rdata;
	logic [pksc_pkg::CELL_AW-1:0] tcell_d, tcell_q;

	assign l2c_raddr = cmd.accept ? lt.idx : c2l_rdata;
	assign c2l_raddr = cmd.accept ? cell_in : tcell_d;

	pksc_ram #(.WIDTH(2 * CW), .DEPTH(pksc_pkg::LETTERS)) u_l2c (
		.clk   (clk),
		.we    (cmd.wr_set),
		.waddr (li_q),
		.wdata ({row_q, col_q}),
		.re    (cmd.accept || cmd.wr_old),
		.raddr (l2c_raddr),
		.rdata (l2c_rdata)
	);

	pksc_ram #(.WIDTH(LW), .DEPTH(pksc_pkg::CELLS)) u_c2l (
		.clk   (clk),
		.we    (cmd.wr_set),
		.waddr (cell_q),
		.wdata (li_q),
		.re    (cmd.accept || cmd.shift),
		.raddr (c2l_raddr),
		.rdata (c2l_rdata)
	);

	pksc_ram #(.WIDTH(pksc_pkg::KEY_VW), .DEPTH(pksc_pkg::KEY_DEPTH)) u_key (
		.clk   (clk),
		.we    (key_wr),
		.waddr (key_count_q[pksc_pkg::KEY_AW-1:0]),
		.wdata (key_val),
		.re    (cmd.accept),
		.raddr (kp),
		.rdata (key_rdata)
	);

	// valid bits
	logic          l2c_v_q [pksc_pkg::LETTERS];
	logic          c2l_v_q [pksc_pkg::CELLS];
	logic [LW-1:0] old_q;
	logic          old_v_q;
	logic          old_clr;

	always_ff @(posedge clk) begin
		if (cmd.wr_old) begin
			old_q   <= c2l_rdata;
			old_v_q <= c2l_v_q[cell_q];
		end
	end

	assign old_clr = old_v_q && (int'(old_q) < pksc_pkg::LETTERS)
		&& l2c_v_q[old_q] && (l2c_rdata == {row_q, col_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pksc_pkg::LETTERS; i++) l2c_v_q[i] <= 1'b0;
			for (int i = 0; i < pksc_pkg::CELLS; i++)   c2l_v_q[i] <= 1'b0;
		end else if (cmd.wr_set) begin
			// drop the old letter's lookup if it still points at this cell, unless the same letter is set again here
			if (old_clr && (old_q != li_q)) l2c_v_q[old_q] <= 1'b0;
			l2c_v_q[li_q]   <= 1'b1;
			c2l_v_q[cell_q] <= 1'b1;
		end
	end

	// key position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q <= '0;
			key_pos_q   <= '0;
		end else begin
			if (key_wr) key_count_q <= key_count_q + pksc_pkg::KEY_CW'(1);
			if (cmd.accept && op == pksc_pkg::CMD_CLEAR) begin
				key_count_q <= '0;
				key_pos_q   <= '0;
			end
			if (cmd.accept && op == pksc_pkg::CMD_RESTART) key_pos_q <= '0;
			if (cmd.look && stat.l2c_hit)
				key_pos_q <= (kp_inc >= key_count_q) ? '0
					: kp_inc[pksc_pkg::KEY_AW-1:0];
		end
	end

	// coordinate shift
	logic [SW-1:0] s_eff;
	logic [SW-1:0] base_r_s1, base_c_s1, km_s1;
	logic [SW-1:0] nr, nc;

	always_comb begin
		if (side_q == '0)
			s_eff = SW'(1);
		else if (int'(side_q) > pksc_pkg::MAX_SIDE)
			s_eff = SW'(pksc_pkg::MAX_SIDE);
		else
			s_eff = SW'(side_q);
	end

	assign stat.l2c_hit = l2c_v_q[li_q];

	always_ff @(posedge clk) begin
		if (cmd.look) begin
			base_r_s1 <= pksc_pkg::mod_side(
				pksc_pkg::KEY_VW'(l2c_rdata[2*CW-1:CW] - CW'(1)), s_eff);
			base_c_s1 <= pksc_pkg::mod_side(
				pksc_pkg::KEY_VW'(l2c_rdata[CW-1:0] - CW'(1)), s_eff);
			km_s1     <= pksc_pkg::mod_side(key_rdata, s_eff);
		end
	end

	assign nr      = pksc_pkg::shift_coord(base_r_s1, km_s1, s_eff, decrypt_q);
	assign nc      = pksc_pkg::shift_coord(base_c_s1, km_s1, s_eff, decrypt_q);
	assign tcell_d = pksc_pkg::CELL_AW'(int'(nr) * pksc_pkg::MAX_SIDE + int'(nc));

	always_ff @(posedge clk) begin
		if (cmd.shift) tcell_q <= tcell_d;
	end

	// result hold and output register
	logic [pksc_pkg::CHAR_W-1:0] res_char_q;
	pksc_pkg::status_t           res_st_q;
	logic                        m_tvalid_q;
	logic [pksc_pkg::CHAR_W-1:0] m_char_q;
	logic [1:0]                  m_st_q;

	always_ff @(posedge clk) begin
		priority if (cmd.accept) begin
			res_char_q <= '0;
			res_st_q   <= pksc_pkg::ST_KEY_EMPTY;
		end else if (cmd.look) begin
			res_char_q <= '0;
			res_st_q   <= pksc_pkg::ST_NO_LETTER;
		end else if (cmd.fetch) begin
			if (c2l_v_q[tcell_q]) begin
				res_char_q <= pksc_pkg::CHAR_A + pksc_pkg::CHAR_W'(c2l_rdata);
				res_st_q   <= pksc_pkg::ST_OK;
			end else begin
				res_char_q <= '0;
				res_st_q   <= pksc_pkg::ST_CELL_EMPTY;
			end
		end
	end

	assign stat.out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)           m_tvalid_q <= 1'b0;
		else if (cmd.emit)     m_tvalid_q <= 1'b1;
		else if (m_tready)     m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			m_char_q <= res_char_q;
			m_st_q   <= res_st_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_char_q;
	assign m_tuser  = m_st_q;

endmodule

// File: rtl/core/polybius_key_shift_cipher.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake            Payload
// s_*       in   s_tvalid / s_tready  s_tuser cmd; s_tdata cell_row, cell_col, char_in
// m_*       out  m_tvalid / m_tready  m_tuser status; m_tdata out_char
// cfg_*     in   cfg_we (no wait)     cfg_idx register index; cfg_data value
//
// One request at a time. Key appends, key clear, restart and dropped requests finish
// in the cycle they are accepted; a cell write reads the cell, reads the old letter's
// lookup, then writes both tables. A text letter passes through the
// letter lookup, the modulo stage, the target cell read and the result hold; an
// empty key goes straight to the result hold, a missing letter after the lookup.
// A result stalled on m_tready waits in the output register while requests that
// give no result keep flowing; the next result then waits in the result hold
// with s_tready low until the output register frees. Reset clears all table
// valid bits at once; no clearing pass is needed.

module polybius_key_shift_cipher (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write port
	input  logic                          cfg_we,
	input  logic [pksc_pkg::CFG_IW-1:0]   cfg_idx,
	input  logic [pksc_pkg::CFG_DW-1:0]   cfg_data,
	// request stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [pksc_pkg::IN_W-1:0]     s_tdata,   // [2:0] cell_row, [5:3] cell_col, [13:6] char_in
	input  logic [pksc_pkg::FIELD_W-1:0]  s_tuser,   // [2:0] cmd
	// result stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [pksc_pkg::CHAR_W-1:0]   m_tdata,   // [7:0] out_char
	output logic [1:0]                    m_tuser    // [1:0] status
);

	pksc_pkg::ctrl_cmd_t cmd;
	pksc_pkg::dp_stat_t  stat;

	// sequence each request; ready only while waiting for the next one
	pksc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.stat     (stat),
		.s_tready (s_tready),
		.cmd      (cmd)
	);

	// tables, key store, coordinate arithmetic and the output register
	pksc_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.in_cmd   (s_tuser),
		.in_data  (s_tdata),
		.m_tready (m_tready),
		.cmd      (cmd),
		.stat     (stat),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

// File: rtl/core/pksc_checker.sv
`timescale 1ns / 1ps

module pksc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [pksc_pkg::FIELD_W-1:0]  s_tuser,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [pksc_pkg::CHAR_W-1:0]   m_tdata,
	input logic [1:0]                    m_tuser
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// failed lookups carry no letter
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != pksc_pkg::ST_OK) |-> m_tdata == '0)
		else $error("nonzero char with failure status");

	// good results are uppercase letters
	a_ok_letter: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == pksc_pkg::ST_OK)
		|-> m_tdata >= pksc_pkg::CHAR_A && m_tdata <= pksc_pkg::CHAR_A + pksc_pkg::LETTER_SPAN)
		else $error("ok result is not an uppercase letter");

	// key, key clear and restart requests never block the next request
	a_quick_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == pksc_pkg::CMD_KEY
			|| s_tuser == pksc_pkg::CMD_CLEAR || s_tuser == pksc_pkg::CMD_RESTART)
		|=> s_tready)
		else $error("single-cycle request left the block busy");

	// a new result is loaded only while the block is busy
	a_out_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result appeared without a request in flight");

endmodule

bind polybius_key_shift_cipher pksc_checker u_pksc_checker (.*);

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	// Command codes that the block leaves unused; they must do nothing.
	localparam logic [pksc_pkg::FIELD_W-1:0] CMD_SPARE_LO  = 3'd5;
	localparam logic [pksc_pkg::FIELD_W-1:0] CMD_SPARE_MID = 3'd6;
	localparam logic [pksc_pkg::FIELD_W-1:0] CMD_SPARE_HI  = 3'd7;

	localparam int STALL_LIMIT = 3000;   // cycles with no handshake before giving up
	localparam int HOLD_CYCLES = 300;    // long receiver hold-off
	localparam int HOLD_MARK   = 200;    // results between hold-offs
	localparam int SETTLE      = 8;      // margin for a trailing cell write to finish
	localparam int N_PHASES    = 10;

	typedef struct {
		logic [pksc_pkg::FIELD_W-1:0] cmd;
		logic [2:0]                   row;
		logic [2:0]                   col;
		logic [pksc_pkg::CHAR_W-1:0]  ch;
	} req_t;

	typedef struct {
		logic [pksc_pkg::CHAR_W-1:0] ch;
		pksc_pkg::status_t           st;
	} reply_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_we = 1'b0;
	logic [pksc_pkg::CFG_IW-1:0]    cfg_idx = '0;
	logic [pksc_pkg::CFG_DW-1:0]    cfg_data = '0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [pksc_pkg::IN_W-1:0]      s_tdata = '0;
	logic [pksc_pkg::FIELD_W-1:0]   s_tuser = '0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [pksc_pkg::CHAR_W-1:0]    m_tdata;
	logic [1:0]                     m_tuser;

	polybius_key_shift_cipher u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // [2:0] cell_row, [5:3] cell_col, [13:6] char_in
		.s_tuser  (s_tuser),   // [2:0] cmd
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // [7:0] out_char
		.m_tuser  (m_tuser)    // [1:0] status
	);

	// Register settings per random phase: extremes of the side size included,
	// side 0 and side 7 both fold into the legal range.
	int plan_dec[N_PHASES]  = '{1, 0, 1, 0, 1, 0, 1, 0, 1, 0};
	int plan_side[N_PHASES] = '{5, 6, 6, 1, 0, 7, 3, 2, 4, 5};
	int plan_kind[N_PHASES] = '{0, 1, 1, 0, 1, 0, 1, 1, 0, 0};

	// Shadow of the block: configuration, square in both directions, key.
	bit          decrypt_on = 1'b0;
	logic [2:0]  side_reg = pksc_pkg::SIDE_RESET;
	bit          key_by_letter = 1'b0;
	bit          at_ok[pksc_pkg::LETTERS];
	int          at_row[pksc_pkg::LETTERS];
	int          at_col[pksc_pkg::LETTERS];
	bit          sq_full[pksc_pkg::CELLS];
	int          sq_letter[pksc_pkg::CELLS];
	int          key_vals[pksc_pkg::KEY_DEPTH];
	int          key_len = 0;
	int          key_at = 0;

	req_t        pending_reqs[$];
	reply_t      expected_out[$];
	req_t        cur_req;
	reply_t      want;

	bit          no_gaps = 1'b0;
	int          n_req = 0;
	int          n_reply = 0;
	int          n_errors = 0;
	int          st_count[4] = '{0, 0, 0, 0};
	int          hold_left = 0;
	int          holds_done = 0;
	int          idle_cycles = 0;

	initial begin
		forever #6 clk = ~clk;
	end

	task automatic flag_mismatch(input string msg);
		n_errors++;
		$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// Letter position 0..25 for either case, -1 for anything else.
	function automatic int alpha_pos(input logic [pksc_pkg::CHAR_W-1:0] c);
		if (c >= "A" && c <= "Z") return int'(c) - int'(pksc_pkg::CHAR_A);
		if (c >= "a" && c <= "z")
			return int'(c) - int'(pksc_pkg::CHAR_A) - int'(pksc_pkg::CASE_OFS);
		return -1;
	endfunction

	// Move one coordinate by the key value, wrapping inside 1..s.
	function automatic int wrap_shift(input int coord, input int kv, input int s);
		int base;
		int k;
		base = (coord - 1) % s;
		k = kv % s;
		if (decrypt_on) return ((base + s - k) % s) + 1;
		return ((base + k) % s) + 1;
	endfunction

	// Apply one accepted request to the shadow state and queue its result, if any.
	task automatic cipher_apply(input req_t r);
		int     li;
		int     v;
		int     s;
		int     kp;
		int     kv;
		int     nr;
		int     nc;
		int     tgt;
		int     old;
		reply_t rep;
		li = alpha_pos(r.ch);
		case (r.cmd)
			pksc_pkg::CMD_CELL: begin
				// drop bad coordinates and non-letters
				if (li >= 0 && r.row >= 1 && r.row <= pksc_pkg::MAX_SIDE && r.col >= 1 &&
						r.col <= pksc_pkg::MAX_SIDE) begin
					tgt = (int'(r.row) - 1) * pksc_pkg::MAX_SIDE + (int'(r.col) - 1);
					// the displaced letter forgets this cell only if it still points here
					if (sq_full[tgt]) begin
						old = sq_letter[tgt];
						if (at_ok[old] && at_row[old] == r.row && at_col[old] == r.col)
							at_ok[old] = 1'b0;
					end
					sq_full[tgt] = 1'b1;
					sq_letter[tgt] = li;
					at_ok[li] = 1'b1;
					at_row[li] = r.row;
					at_col[li] = r.col;
				end
			end
			pksc_pkg::CMD_KEY: begin
				v = -1;
				if (!key_by_letter) begin
					if (r.ch >= pksc_pkg::CHAR_0 &&
							r.ch <= pksc_pkg::CHAR_0 + pksc_pkg::DIGIT_SPAN)
						v = int'(r.ch - pksc_pkg::CHAR_0);
				end else if (li >= 0) begin
					v = li + 1;
				end
				// foreign characters and appends to a full key are dropped
				if (v >= 0 && key_len < pksc_pkg::KEY_DEPTH) begin
					key_vals[key_len] = v;
					key_len++;
				end
			end
			pksc_pkg::CMD_CLEAR: begin
				key_len = 0;
				key_at = 0;
			end
			pksc_pkg::CMD_RESTART: key_at = 0;
			pksc_pkg::CMD_TEXT: begin
				if (li >= 0) begin
					rep.ch = '0;
					if (key_len == 0) begin
						rep.st = pksc_pkg::ST_KEY_EMPTY;
					end else if (!at_ok[li]) begin
						rep.st = pksc_pkg::ST_NO_LETTER;
					end else begin
						s = side_reg;
						if (s == 0) s = 1;
						if (s > pksc_pkg::MAX_SIDE) s = pksc_pkg::MAX_SIDE;
						kp = (key_at < key_len) ? key_at : 0;
						kv = key_vals[kp];
						nr = wrap_shift(at_row[li], kv, s);
						nc = wrap_shift(at_col[li], kv, s);
						tgt = (nr - 1) * pksc_pkg::MAX_SIDE + (nc - 1);
						// the key advances even when the target cell is empty
						kp++;
						key_at = (kp >= key_len) ? 0 : kp;
						if (sq_full[tgt]) begin
							rep.ch = 8'(int'(pksc_pkg::CHAR_A) + sq_letter[tgt]);
							rep.st = pksc_pkg::ST_OK;
						end else begin
							rep.st = pksc_pkg::ST_CELL_EMPTY;
						end
					end
					expected_out.push_back(rep);
				end
			end
			default: ;
		endcase
	endtask

	task automatic push_req(input logic [pksc_pkg::FIELD_W-1:0] cmd, input logic [2:0] row,
			input logic [2:0] col, input logic [pksc_pkg::CHAR_W-1:0] ch);
		req_t r;
		r.cmd = cmd;
		r.row = row;
		r.col = col;
		r.ch = ch;
		pending_reqs.push_back(r);
	endtask

	function automatic logic [pksc_pkg::CHAR_W-1:0] rand_letter();
		return 8'(int'(pksc_pkg::CHAR_A) + $urandom_range(0, 25) +
			($urandom_range(0, 1) ? int'(pksc_pkg::CASE_OFS) : 0));
	endfunction

	// Key character of the current kind, now and then a stray byte.
	function automatic logic [pksc_pkg::CHAR_W-1:0] key_char();
		if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
		if (key_by_letter) return rand_letter();
		return 8'(int'(pksc_pkg::CHAR_0) + $urandom_range(0, 9));
	endfunction

	// One well-formed session: partial square, fresh key, then text with some noise.
	task automatic queue_phase(input bit long_key);
		int s;
		int len;
		int pick;
		s = (side_reg == 0) ? 1 : (side_reg > pksc_pkg::MAX_SIDE) ? pksc_pkg::MAX_SIDE
			: int'(side_reg);
		for (int r = 1; r <= s; r++) begin
			for (int c = 1; c <= s; c++) begin
				if ($urandom_range(0, 99) < 70)
					push_req(pksc_pkg::CMD_CELL, 3'(r), 3'(c), rand_letter());
			end
		end
		push_req(pksc_pkg::CMD_CLEAR, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
			8'($urandom_range(0, 255)));
		len = long_key ? pksc_pkg::KEY_DEPTH + 6 : $urandom_range(1, 8);
		repeat (len) push_req(pksc_pkg::CMD_KEY, 3'($urandom_range(0, 7)),
			3'($urandom_range(0, 7)), key_char());
		repeat (127) begin
			pick = $urandom_range(0, 99);
			if (pick < 78) begin
				push_req(pksc_pkg::CMD_TEXT, 3'($urandom_range(0, 7)),
					3'($urandom_range(0, 7)), rand_letter());
			end else if (pick < 86) begin
				push_req(pksc_pkg::CMD_TEXT, 3'($urandom_range(0, 7)),
					3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
			end else if (pick < 89) begin
				push_req(pksc_pkg::CMD_RESTART, 3'($urandom_range(0, 7)),
					3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
			end else if (pick < 91) begin
				push_req(pksc_pkg::CMD_KEY, 3'($urandom_range(0, 7)),
					3'($urandom_range(0, 7)), key_char());
			end else if (pick < 93) begin
				push_req(pksc_pkg::CMD_CELL, 3'($urandom_range(1, s)),
					3'($urandom_range(1, s)), rand_letter());
			end else begin
				push_req(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
					3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
			end
		end
	endtask

	// Write all three registers; only called while the block is idle.
	task automatic set_mode(input bit dec, input logic [2:0] side, input bit kind);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= pksc_pkg::CFG_DECRYPT;
		cfg_data <= {2'b00, dec};
		@(posedge clk);
		cfg_idx <= pksc_pkg::CFG_SIDE;
		cfg_data <= side;
		@(posedge clk);
		cfg_idx <= pksc_pkg::CFG_KEY_KIND;
		cfg_data <= {2'b00, kind};
		@(posedge clk);
		cfg_we <= 1'b0;
		decrypt_on = dec;
		side_reg = side;
		key_by_letter = kind;
	endtask

	// Hold until every request went in and every result came out, then let
	// a trailing cell write finish.
	task automatic wait_drained();
		do @(negedge clk);
		while (pending_reqs.size() != 0 || s_tvalid || expected_out.size() != 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	// Driver: predict on acceptance, then offer the next request or idle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				cipher_apply(cur_req);
				n_req++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_reqs.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 7)) begin
					cur_req = pending_reqs.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {2'b00, cur_req.ch, cur_req.col, cur_req.row};
					s_tuser <= cur_req.cmd;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each result against the oldest prediction, and pace m_tready.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_out.size() == 0) begin
					flag_mismatch($sformatf("unexpected result char %h status %0d",
						m_tdata, m_tuser));
				end else begin
					want = expected_out.pop_front();
					st_count[want.st]++;
					if (m_tdata !== want.ch)
						flag_mismatch($sformatf("result %0d char %h, want %h",
							n_reply, m_tdata, want.ch));
					if (m_tuser !== want.st)
						flag_mismatch($sformatf("result %0d status %0d, want %0d",
							n_reply, m_tuser, want.st));
				end
				n_reply++;
			end
			// Long hold-off now and then, so the output register fills and the
			// block has to stall incoming requests.
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (holds_done < 2 && n_reply >= HOLD_MARK * (holds_done + 1)) begin
				hold_left = HOLD_CYCLES - 1;
				holds_done++;
				m_tready <= 1'b0;
			end else begin
				m_tready <= no_gaps || ($urandom_range(0, 99) >= 7);
			end
		end
	end

	// Watchdog: give up when nothing moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout: no handshake for %0d cycles", idle_cycles);
			$display("RESULT: ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		for (int i = 0; i < pksc_pkg::LETTERS; i++) at_ok[i] = 1'b0;
		for (int i = 0; i < pksc_pkg::CELLS; i++) sq_full[i] = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed requests under the reset settings (encrypt, side 5, digit key).
		push_req(pksc_pkg::CMD_TEXT, 3'd0, 3'd0, "A");     // empty key beats missing letter
		push_req(pksc_pkg::CMD_CELL, 3'd1, 3'd1, "A");
		push_req(pksc_pkg::CMD_CELL, 3'd1, 3'd2, "b");
		push_req(pksc_pkg::CMD_CELL, 3'd6, 3'd6, "Z");
		push_req(pksc_pkg::CMD_CELL, 3'd0, 3'd3, "M");     // bad row, drop
		push_req(pksc_pkg::CMD_CELL, 3'd2, 3'd7, "M");     // bad column, drop
		push_req(pksc_pkg::CMD_CELL, 3'd2, 3'd2, "5");     // not a letter, drop
		push_req(pksc_pkg::CMD_CELL, 3'd1, 3'd1, "C");     // overwrite, A loses its cell
		push_req(pksc_pkg::CMD_KEY, 3'd7, 3'd7, "3");
		push_req(pksc_pkg::CMD_KEY, 3'd0, 3'd0, "x");      // letter under digit key, drop
		push_req(pksc_pkg::CMD_TEXT, 3'd0, 3'd0, "a");     // missing letter
		push_req(pksc_pkg::CMD_TEXT, 3'd0, 3'd0, "C");     // target cell empty
		push_req(pksc_pkg::CMD_TEXT, 3'd0, 3'd0, "!");     // no result
		push_req(pksc_pkg::CMD_CELL, 3'd4, 3'd4, "Q");
		push_req(pksc_pkg::CMD_TEXT, 3'd0, 3'd0, "c");
		push_req(pksc_pkg::CMD_TEXT, 3'd7, 3'd7, "Z");     // row and column beyond the side
		push_req(CMD_SPARE_LO, 3'd1, 3'd1, "A");
		push_req(CMD_SPARE_MID, 3'd2, 3'd2, "B");
		push_req(CMD_SPARE_HI, 3'd1, 3'd1, "A");
		push_req(pksc_pkg::CMD_KEY, 3'd0, 3'd0, "9");
		push_req(pksc_pkg::CMD_TEXT, 3'd0, 3'd0, "B");
		push_req(pksc_pkg::CMD_RESTART, 3'd0, 3'd0, 8'hff);
		push_req(pksc_pkg::CMD_TEXT, 3'd0, 3'd0, 8'hff);
		push_req(pksc_pkg::CMD_TEXT, 3'd0, 3'd0, 8'h00);
		push_req(pksc_pkg::CMD_CLEAR, 3'd0, 3'd0, 8'h00);
		push_req(pksc_pkg::CMD_TEXT, 3'd0, 3'd0, "Q");     // key empty again
		wait_drained();

		// Random sessions, one register setting each.
		for (int p = 0; p < N_PHASES; p++) begin
			set_mode(plan_dec[p][0], 3'(plan_side[p]), plan_kind[p][0]);
			@(negedge clk);
			no_gaps = (p == 2);
			queue_phase(p == 4);
			wait_drained();
			no_gaps = 1'b0;
		end

		repeat (20) @(negedge clk);
		if (expected_out.size() != 0)
			flag_mismatch($sformatf("%0d results never arrived", expected_out.size()));
		$display("covered %0d requests across %0d register settings, %0d results checked",
			n_req, N_PHASES + 1, n_reply);
		$display("status mix: ok %0d, no letter %0d, key empty %0d, cell empty %0d",
			st_count[pksc_pkg::ST_OK], st_count[pksc_pkg::ST_NO_LETTER],
			st_count[pksc_pkg::ST_KEY_EMPTY], st_count[pksc_pkg::ST_CELL_EMPTY]);
		if (n_errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// File: polybius_key_shift_cipher.f
rtl/core/pksc_pkg.sv
rtl/core/pksc_ram.sv
rtl/core/pksc_ctrl.sv
rtl/core/pksc_dp.sv
rtl/core/polybius_key_shift_cipher.sv
rtl/core/pksc_checker.sv
dv/tb_top.sv
